/* rtl/cdc_pkg.sv */
// Shared widths, constants and calendar helper functions for the date converter.
package cdc_pkg;

	localparam int YEAR_W = 12;
	localparam int MON_W  = 4;
	localparam int DAY_W  = 5;
	localparam int CNT_W  = 17;
	localparam int WD_W   = 3;
	localparam int ACC_W  = 19;  // holds a full span of 1024 years of days
	localparam int LEN_W  = 9;   // days in a year
	localparam int R400_W = 9;   // year position inside the 400-year cycle

	localparam logic [CNT_W-1:0]  COUNT_MAX    = 17'h1FFFF;
	localparam logic [MON_W-1:0]  MONTH_FIRST  = 4'd1;
	localparam logic [MON_W-1:0]  MONTH_LAST   = 4'd12;
	localparam logic [LEN_W-1:0]  DAYS_COMMON  = 9'd365;
	localparam logic [LEN_W-1:0]  DAYS_LEAP    = 9'd366;
	localparam logic [DAY_W-1:0]  FEB_SHORT    = 5'd28;
	localparam logic [R400_W-1:0] CYCLE_LAST   = 9'd399;
	localparam logic [WD_W-1:0]   WEEK_LEN     = 3'd7;

	// Leap rule from the position in the 400-year cycle: every fourth year,
	// except the three century years that are not a multiple of 400.
	function automatic logic leap_of(input logic [R400_W-1:0] r);
		logic century;
		century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
		return (r[1:0] == 2'd0) && !century;
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] d;
		unique case (m)
			4'd2:                      d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:        d = 5'd31;
			default:                   d = 5'd30;
		endcase
		return d;
	endfunction

	// Sum of two weekday offsets, modulo a week.
	function automatic logic [WD_W-1:0] wd_add(input logic [WD_W-1:0] a,
			input logic [WD_W-1:0] b);
		logic [WD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, WEEK_LEN}) begin
			s = s - {1'b0, WEEK_LEN};
		end
		return s[WD_W-1:0];
	endfunction

	// Weekday offset of a day of month: (d - 1) mod 7, d from 1 to 31.
	function automatic logic [WD_W-1:0] day_wd(input logic [DAY_W-1:0] d);
		logic [DAY_W-1:0] v;
		v = d - 5'd1;
		for (int i = 0; i < 4; i++) begin
			if (v >= {2'b0, WEEK_LEN}) begin
				v = v - {2'b0, WEEK_LEN};
			end
		end
		return v[WD_W-1:0];
	endfunction

endpackage

/* rtl/cdc_req_if.sv */
// Request channel of the date converter: valid/ready handshake and input fields.
interface cdc_req_if import cdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [YEAR_W-1:0] year_in;
	logic [MON_W-1:0]  month_in;
	logic [DAY_W-1:0]  day_in;
	logic [CNT_W-1:0]  count_in;

	modport source (output valid, func, year_in, month_in, day_in, count_in,
		input ready);
	modport sink (input valid, func, year_in, month_in, day_in, count_in,
		output ready);
endinterface

/* rtl/cdc_rsp_if.sv */
// Result channel of the date converter: valid/ready handshake and result fields.
interface cdc_rsp_if import cdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  count_out;
	logic [YEAR_W-1:0] year_out;
	logic [MON_W-1:0]  month_out;
	logic [DAY_W-1:0]  day_out;
	logic [WD_W-1:0]   weekday;
	logic              valid_res;

	modport source (output valid, count_out, year_out, month_out, day_out, weekday,
		valid_res, input ready);
	modport sink (input valid, count_out, year_out, month_out, day_out, weekday,
		valid_res, output ready);
endinterface

/* rtl/calendar_date_day_count_converter.sv */
// Top level of the calendar date / day number converter (iterative sequencer).
// Converts a Gregorian date to a day number (day 1 = 1 January of EPOCH_YEAR)
// when func is 0, and a day number back to a date when func is 1; both modes
// also return the weekday (0 Monday .. 6 Sunday) and a valid flag, and every
// field is 0 when the date or day number lies outside the span of YEAR_SPAN
// years. A request is first taken; then the walk steps one year at a time
// from EPOCH_YEAR to the target year, then one month at a time up to the
// target month, and last the result is posted. The pace is set by the
// single add/subtract unit that walks the years and months.
// The block takes no request while one is in progress, but it takes the next
// one while the last result still waits in the output register.
module calendar_date_day_count_converter import cdc_pkg::*; #(
	parameter int EPOCH_YEAR = 1900,
	parameter int YEAR_SPAN  = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	cdc_req_if.sink   req,
	cdc_rsp_if.source rsp
);

	localparam logic [YEAR_W-1:0] FIRST_YEAR = YEAR_W'(EPOCH_YEAR);
	localparam logic [YEAR_W-1:0] LAST_YEAR  = YEAR_W'(EPOCH_YEAR + YEAR_SPAN - 1);
	localparam logic [R400_W-1:0] R400_INIT  = R400_W'(EPOCH_YEAR % 400);

	typedef enum logic [1:0] {
		S_IDLE,
		S_YEARS,
		S_MONTHS,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic              func_q;
	logic              ok_q;
	logic [YEAR_W-1:0] yr_q;       // year being walked
	logic [YEAR_W-1:0] yr_tgt_q;   // requested year (date mode)
	logic [MON_W-1:0]  mon_q;      // month being walked
	logic [MON_W-1:0]  mon_tgt_q;  // requested month (date mode)
	logic [DAY_W-1:0]  day_q;
	logic [CNT_W-1:0]  cnt_q;      // requested day number (count mode)
	logic [ACC_W-1:0]  acc_q;      // running total or remaining days
	logic [WD_W-1:0]   wd_q;       // running weekday offset
	logic [R400_W-1:0] r400_q;     // yr_q modulo 400

	logic              rsp_valid_q;
	logic [CNT_W-1:0]  count_out_q;
	logic [YEAR_W-1:0] year_out_q;
	logic [MON_W-1:0]  month_out_q;
	logic [DAY_W-1:0]  day_out_q;
	logic [WD_W-1:0]   weekday_q;
	logic              valid_res_q;

	logic              leap;
	logic [DAY_W-1:0]  dim;
	logic [LEN_W-1:0]  diy;
	logic [LEN_W-1:0]  alu_b;
	logic [ACC_W-1:0]  alu_res;
	logic              alu_gt;
	logic              req_ok;

	// Length of the current year and month drive the shared unit.
	assign leap  = leap_of(r400_q);
	assign dim   = month_days(mon_q, leap);
	assign diy   = leap ? DAYS_LEAP : DAYS_COMMON;
	assign alu_b = (state_q == S_YEARS) ? diy : LEN_W'(dim);

	cdc_alu u_alu (
		.a   (acc_q),
		.b   (alu_b),
		.sub (func_q),
		.res (alu_res),
		.gt  (alu_gt)
	);

	// Checks that need no walk; the day against the month length waits
	// until the walk reaches the requested year and knows its leap status.
	always_comb begin
		if (req.func) begin
			req_ok = req.count_in != '0;
		end else begin
			req_ok = (req.year_in >= FIRST_YEAR) && (req.year_in <= LAST_YEAR) &&
				(req.month_in >= MONTH_FIRST) && (req.month_in <= MONTH_LAST) &&
				(req.day_in != '0);
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.count_out = count_out_q;
	assign rsp.year_out  = year_out_q;
	assign rsp.month_out = month_out_q;
	assign rsp.day_out   = day_out_q;
	assign rsp.weekday   = weekday_q;
	assign rsp.valid_res = valid_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			func_q      <= 1'b0;
			ok_q        <= 1'b0;
			yr_q        <= '0;
			yr_tgt_q    <= '0;
			mon_q       <= '0;
			mon_tgt_q   <= '0;
			day_q       <= '0;
			cnt_q       <= '0;
			acc_q       <= '0;
			wd_q        <= '0;
			r400_q      <= '0;
			count_out_q <= '0;
			year_out_q  <= '0;
			month_out_q <= '0;
			day_out_q   <= '0;
			weekday_q   <= '0;
			valid_res_q <= 1'b0;
		end else begin
			// Drop the result once the sink takes it, unless a new one replaces it.
			if (rsp.valid && rsp.ready && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						func_q    <= req.func;
						ok_q      <= req_ok;
						yr_q      <= FIRST_YEAR;
						r400_q    <= R400_INIT;
						mon_q     <= MONTH_FIRST;
						yr_tgt_q  <= req.year_in;
						mon_tgt_q <= req.month_in;
						day_q     <= req.day_in;
						cnt_q     <= req.count_in;
						acc_q     <= req.func ? ACC_W'(req.count_in) : ACC_W'(req.day_in);
						wd_q      <= req.func ? '0 : day_wd(req.day_in);
						state_q   <= req_ok ? S_YEARS : S_FINISH;
					end
				end
				S_YEARS: begin
					if (!func_q) begin
						// Date mode: add whole years until the requested one.
						if (yr_q == yr_tgt_q) begin
							if (day_q > month_days(mon_tgt_q, leap)) begin
								ok_q    <= 1'b0;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_MONTHS;
							end
						end else begin
							acc_q  <= alu_res;
							wd_q   <= wd_add(wd_q, leap ? 3'd2 : 3'd1);
							yr_q   <= yr_q + YEAR_W'(1);
							r400_q <= (r400_q == CYCLE_LAST) ? '0 : r400_q + R400_W'(1);
						end
					end else begin
						// Count mode: strip whole years while more remain.
						if (alu_gt) begin
							if (yr_q == LAST_YEAR) begin
								ok_q    <= 1'b0;
								state_q <= S_FINISH;
							end else begin
								acc_q  <= alu_res;
								wd_q   <= wd_add(wd_q, leap ? 3'd2 : 3'd1);
								yr_q   <= yr_q + YEAR_W'(1);
								r400_q <= (r400_q == CYCLE_LAST) ? '0 : r400_q + R400_W'(1);
							end
						end else begin
							state_q <= S_MONTHS;
						end
					end
				end
				S_MONTHS: begin
					if (!func_q) begin
						if (mon_q == mon_tgt_q) begin
							ok_q    <= acc_q <= ACC_W'(COUNT_MAX);
							state_q <= S_FINISH;
						end else begin
							acc_q <= alu_res;
							wd_q  <= wd_add(wd_q, WD_W'(dim - FEB_SHORT));
							mon_q <= mon_q + MON_W'(1);
						end
					end else begin
						if ((mon_q < MONTH_LAST) && alu_gt) begin
							acc_q <= alu_res;
							wd_q  <= wd_add(wd_q, WD_W'(dim - FEB_SHORT));
							mon_q <= mon_q + MON_W'(1);
						end else begin
							// The rest is the day of month; fold it into the weekday.
							wd_q    <= wd_add(wd_q, day_wd(acc_q[DAY_W-1:0]));
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					// Hold until the output register is free, then post the result.
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						valid_res_q <= ok_q;
						weekday_q   <= ok_q ? wd_q : '0;
						if (!ok_q) begin
							count_out_q <= '0;
							year_out_q  <= '0;
							month_out_q <= '0;
							day_out_q   <= '0;
						end else if (!func_q) begin
							count_out_q <= acc_q[CNT_W-1:0];
							year_out_q  <= yr_tgt_q;
							month_out_q <= mon_tgt_q;
							day_out_q   <= day_q;
						end else begin
							count_out_q <= cnt_q;
							year_out_q  <= yr_q;
							month_out_q <= mon_q;
							day_out_q   <= acc_q[DAY_W-1:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// An invalid result carries zeros in every field.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.valid_res |-> (rsp.count_out == '0) &&
			(rsp.year_out == '0) && (rsp.month_out == '0) &&
			(rsp.day_out == '0) && (rsp.weekday == '0))
		else $error("invalid result with nonzero fields");

	// A valid result is a real calendar date with a real weekday.
	a_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.valid_res |-> (rsp.month_out >= MONTH_FIRST) &&
			(rsp.month_out <= MONTH_LAST) && (rsp.day_out != '0) &&
			(rsp.weekday < WEEK_LEN) && (rsp.count_out != '0))
		else $error("valid result out of calendar range");

	// A taken request puts the block to work.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken but block still idle");

endmodule

/* rtl/cdc_alu.sv */
// Shared add/subtract and compare unit of the date converter.
module cdc_alu import cdc_pkg::*; (
	input  logic [ACC_W-1:0] a,
	input  logic [LEN_W-1:0] b,
	input  logic             sub,
	output logic [ACC_W-1:0] res,
	output logic             gt
);
	logic [ACC_W-1:0] b_ext;

	assign b_ext = ACC_W'(b);
	assign res   = sub ? (a - b_ext) : (a + b_ext);
	assign gt    = a > b_ext;
endmodule

/* tb/tb_calendar_date_day_count_converter.sv */
// Testbench for the date / day number converter: directed table, random requests, predictor.
module tb_calendar_date_day_count_converter import cdc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Block configuration; the predictor works from the same span.
	localparam int FIRST_YEAR = 1900;
	localparam int SPAN_YEARS = 256;
	localparam int LAST_YEAR  = FIRST_YEAR + SPAN_YEARS - 1;

	// Conversion direction carried by the func field.
	localparam logic FUNC_DATE_TO_COUNT = 1'b0;
	localparam logic FUNC_COUNT_TO_DATE = 1'b1;

	// Receiver stall patterns.
	localparam int RDY_ALWAYS = 0;
	localparam int RDY_COIN   = 1;
	localparam int RDY_HOLD   = 2;
	localparam int RDY_TOGGLE = 3;

	localparam int N_DIRECTED   = 24;
	localparam int N_RANDOM     = 800;
	localparam int DRAIN_CYCLES = 300;     // one full year walk plus margin
	localparam real LIMIT_NS    = 5.0e6;   // far beyond the slowest stalled run

	typedef struct packed {
		logic              func;
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic [CNT_W-1:0]  count;
	} conv_req_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DAY_W-1:0]  day;
		logic [WD_W-1:0]   weekday;
		logic              ok;
	} conv_res_t;

	typedef struct packed {
		conv_req_t stim;
		logic      fixed;      // expected result typed in below
		conv_res_t fixed_res;
	} dir_row_t;

	localparam conv_res_t RES_NONE  = '0;
	localparam conv_res_t RES_EPOCH = '{17'd1, 12'd1900, 4'd1, 5'd1, 3'd0, 1'b1};

	logic clk = 1'b0;
	logic arst_n;

	cdc_req_if req ();
	cdc_rsp_if rsp ();

	calendar_date_day_count_converter #(
		.EPOCH_YEAR(FIRST_YEAR),
		.YEAR_SPAN (SPAN_YEARS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected results of accepted requests, oldest first.
	conv_res_t pending_results[$];
	int unsigned mismatch_count = 0;

	// ------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------
	function automatic bit gregorian_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			2:                     return gregorian_leap(y) ? 29 : 28;
			default:               return 30;
		endcase
	endfunction

	function automatic int unsigned days_of_year(input int unsigned y);
		return gregorian_leap(y) ? 366 : 365;
	endfunction

	function automatic int unsigned span_day_total();
		int unsigned total;
		total = 0;
		for (int unsigned y = FIRST_YEAR; y <= LAST_YEAR; y++) begin
			total += days_of_year(y);
		end
		return total;
	endfunction

	function automatic conv_res_t predict_conversion(input conv_req_t r);
		conv_res_t   res;
		int unsigned total, rest, y, m;
		res = RES_NONE;
		if (r.func == FUNC_DATE_TO_COUNT) begin
			// Check the date first; out-of-range fields leave every output at 0.
			if (r.year >= FIRST_YEAR && r.year <= LAST_YEAR && r.month >= 1 && r.month <= 12
					&& r.day >= 1 && r.day <= days_of_month(r.year, r.month)) begin
				total = r.day;
				for (y = FIRST_YEAR; y < r.year; y++) total += days_of_year(y);
				for (m = 1; m < r.month; m++) total += days_of_month(r.year, m);
				if (total <= COUNT_MAX) begin
					res = '{CNT_W'(total), r.year, r.month, r.day,
						WD_W'((total - 1) % 7), 1'b1};
				end
			end
		end else if (r.count >= 1 && r.count <= span_day_total()) begin
			// Peel off whole years, then whole months; the rest is the day.
			rest = r.count;
			y = FIRST_YEAR;
			while (rest > days_of_year(y)) begin
				rest -= days_of_year(y);
				y++;
			end
			m = 1;
			while (m < 12 && rest > days_of_month(y, m)) begin
				rest -= days_of_month(y, m);
				m++;
			end
			res = '{r.count, YEAR_W'(y), MON_W'(m), DAY_W'(rest),
				WD_W'((r.count - 1) % 7), 1'b1};
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Directed table: extremes, every mode, each kind of rejected input
	// ------------------------------------------------------------------
	dir_row_t directed_rows [0:N_DIRECTED-1] = '{
		// first day of the span
		'{'{FUNC_DATE_TO_COUNT, 12'd1900, 4'd1, 5'd1, 17'd0}, 1'b1, RES_EPOCH},
		// last day of the span, unused count at its top
		'{'{FUNC_DATE_TO_COUNT, 12'd2155, 4'd12, 5'd31, 17'h1FFFF}, 1'b0, RES_NONE},
		// year just below and just above the span
		'{'{FUNC_DATE_TO_COUNT, 12'd1899, 4'd12, 5'd31, 17'd0}, 1'b1, RES_NONE},
		'{'{FUNC_DATE_TO_COUNT, 12'd2156, 4'd1, 5'd1, 17'd0}, 1'b1, RES_NONE},
		// all-zero and all-ones date fields
		'{'{FUNC_DATE_TO_COUNT, 12'd0, 4'd0, 5'd0, 17'd0}, 1'b1, RES_NONE},
		'{'{FUNC_DATE_TO_COUNT, 12'd4095, 4'd15, 5'd31, 17'h1FFFF}, 1'b1, RES_NONE},
		// month 0 and month 13
		'{'{FUNC_DATE_TO_COUNT, 12'd1950, 4'd0, 5'd10, 17'd5}, 1'b1, RES_NONE},
		'{'{FUNC_DATE_TO_COUNT, 12'd1950, 4'd13, 5'd10, 17'd5}, 1'b1, RES_NONE},
		// day 0, and day 31 in a 30-day month
		'{'{FUNC_DATE_TO_COUNT, 12'd1950, 4'd6, 5'd0, 17'd5}, 1'b1, RES_NONE},
		'{'{FUNC_DATE_TO_COUNT, 12'd1950, 4'd4, 5'd31, 17'd5}, 1'b1, RES_NONE},
		// 29 February: century without leap, 400-year leap, century again, plain leap
		'{'{FUNC_DATE_TO_COUNT, 12'd1900, 4'd2, 5'd29, 17'd0}, 1'b1, RES_NONE},
		'{'{FUNC_DATE_TO_COUNT, 12'd2000, 4'd2, 5'd29, 17'd0}, 1'b0, RES_NONE},
		'{'{FUNC_DATE_TO_COUNT, 12'd2100, 4'd2, 5'd29, 17'd0}, 1'b1, RES_NONE},
		'{'{FUNC_DATE_TO_COUNT, 12'd2004, 4'd2, 5'd29, 17'd0}, 1'b0, RES_NONE},
		// ordinary date with garbage in the unused count
		'{'{FUNC_DATE_TO_COUNT, 12'd1901, 4'd1, 5'd31, 17'h15A5A}, 1'b0, RES_NONE},
		// day number 0, date fields ignored
		'{'{FUNC_COUNT_TO_DATE, 12'd2000, 4'd5, 5'd5, 17'd0}, 1'b1, RES_NONE},
		// day number 1 with every unused field at its top
		'{'{FUNC_COUNT_TO_DATE, 12'd4095, 4'd15, 5'd31, 17'd1}, 1'b1, RES_EPOCH},
		// last day of the span, one past it, and the top of the field
		'{'{FUNC_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd93502}, 1'b0, RES_NONE},
		'{'{FUNC_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd93503}, 1'b1, RES_NONE},
		'{'{FUNC_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'h1FFFF}, 1'b1, RES_NONE},
		// 1 March 1900, end of 1900, start of 1901, first Sunday
		'{'{FUNC_COUNT_TO_DATE, 12'd1900, 4'd2, 5'd29, 17'd60}, 1'b0, RES_NONE},
		'{'{FUNC_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd365}, 1'b0, RES_NONE},
		'{'{FUNC_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd366}, 1'b0, RES_NONE},
		'{'{FUNC_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd7}, 1'b0, RES_NONE}
	};

	// ------------------------------------------------------------------
	// Random requests
	// ------------------------------------------------------------------
	function automatic conv_req_t random_request();
		conv_req_t   r;
		int unsigned sel, y, m;
		// Fill every field at full width; modes ignore what they do not use.
		r.func  = 1'($urandom_range(0, 1));
		r.year  = YEAR_W'($urandom());
		r.month = MON_W'($urandom());
		r.day   = DAY_W'($urandom());
		r.count = CNT_W'($urandom());
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			// Well-formed date; keep most years near the epoch so walks stay short.
			r.func = FUNC_DATE_TO_COUNT;
			y = ($urandom_range(0, 9) < 7) ? $urandom_range(FIRST_YEAR, FIRST_YEAR + 63)
				: $urandom_range(FIRST_YEAR, LAST_YEAR);
			m = $urandom_range(1, 12);
			r.year  = YEAR_W'(y);
			r.month = MON_W'(m);
			r.day   = DAY_W'($urandom_range(1, days_of_month(y, m)));
		end else if (sel < 85) begin
			r.func  = FUNC_COUNT_TO_DATE;
			r.count = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom_range(1, 23376))
				: CNT_W'($urandom_range(1, span_day_total()));
		end else if (sel < 92) begin
			r.func = FUNC_DATE_TO_COUNT;
		end else if (sel < 96) begin
			r.func = FUNC_COUNT_TO_DATE;
		end else begin
			// Day numbers around the end of the span.
			r.func  = FUNC_COUNT_TO_DATE;
			r.count = CNT_W'(span_day_total() - 3 + $urandom_range(0, 6));
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side: bursts of back-to-back requests with random gaps
	// ------------------------------------------------------------------
	int unsigned burst_left = 1;

	// Present one request and hold it until the block takes it.
	task automatic send_request(input conv_req_t r, input logic fixed, input conv_res_t fixed_res);
		req.valid    <= 1'b1;
		req.func     <= r.func;
		req.year_in  <= r.year;
		req.month_in <= r.month;
		req.day_in   <= r.day;
		req.count_in <= r.count;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(fixed ? fixed_res : predict_conversion(r));
	endtask

	// Advance the burst; at its end drop valid and idle for a while.
	task automatic pace_requests();
		int unsigned gap, pick;
		burst_left--;
		if (burst_left == 0) begin
			req.valid <= 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 75) gap = $urandom_range(1, 6);
			else if (pick < 95) gap = $urandom_range(7, 60);
			else gap = $urandom_range(200, 320);
			repeat (gap) @(posedge clk);
			// Mostly short bursts, now and then a long unbroken stretch.
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 6);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: stall on a pattern that changes from phase to phase
	// ------------------------------------------------------------------
	int unsigned ready_mode = RDY_ALWAYS;
	int unsigned ready_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (ready_left == 0) begin
				ready_mode = $urandom_range(RDY_ALWAYS, RDY_TOGGLE);
				ready_left = $urandom_range(4, 40);
			end
			ready_left--;
			case (ready_mode)
				RDY_ALWAYS: rsp.ready <= 1'b1;
				RDY_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
				RDY_HOLD:   rsp.ready <= (ready_left == 0);  // hold off until the end of the phase
				default:    rsp.ready <= ~rsp.ready;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result check against the oldest expectation
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		conv_res_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request waiting: count_out %0d", rsp.count_out);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("count_out", want.count, rsp.count_out);
				check_field("year_out", want.year, rsp.year_out);
				check_field("month_out", want.month, rsp.month_out);
				check_field("day_out", want.day, rsp.day_out);
				check_field("weekday", want.weekday, rsp.weekday);
				check_field("valid_res", want.ok, rsp.valid_res);
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.func     <= FUNC_DATE_TO_COUNT;
		req.year_in  <= '0;
		req.month_in <= '0;
		req.day_in   <= '0;
		req.count_in <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, then the random requests.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(directed_rows[i].stim, directed_rows[i].fixed,
				directed_rows[i].fixed_res);
			pace_requests();
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			send_request(random_request(), 1'b0, RES_NONE);
			if (i != N_RANDOM - 1) pace_requests();
		end
		req.valid <= 1'b0;

		// Drain, then watch a while longer for stray results.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("[calendar_date_day_count_converter] OK");
		end else begin
			$display("[calendar_date_day_count_converter] ERROR");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(LIMIT_NS);
		$display("[calendar_date_day_count_converter] ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/cdc_pkg.sv
rtl/cdc_req_if.sv
rtl/cdc_rsp_if.sv
rtl/cdc_alu.sv
rtl/calendar_date_day_count_converter.sv
tb/tb_calendar_date_day_count_converter.sv
